// ===== rtl/gpei_pkg.sv =====
package gpei_pkg;

    typedef enum logic [2:0] {
        FUNC_LATCH  = 3'd0,
        FUNC_PINS   = 3'd1,
        FUNC_DIR    = 3'd2,
        FUNC_IE     = 3'd3,
        FUNC_STAT1  = 3'd4,
        FUNC_STAT2  = 3'd5
    } func_t;

    typedef enum logic [2:0] {
        CFG_OLDER       = 3'd0,
        CFG_PORT_INDEX  = 3'd1,
        CFG_SENSE_ONE   = 3'd2,
        CFG_SENSE_TWO   = 3'd3,
        CFG_SENSE_THREE = 3'd4,
        CFG_SENSE_FOUR  = 3'd5,
        CFG_MODE_ONE    = 3'd6,
        CFG_MODE_TWO    = 3'd7
    } cfg_idx_t;

    localparam logic [3:0] PORT_A = 4'd0;
    localparam logic [3:0] PORT_B = 4'd1;
    localparam logic [3:0] PORT_C = 4'd2;
    localparam logic [3:0] PORT_D = 4'd3;
    localparam logic [3:0] PORT_E = 4'd4;
    localparam logic [3:0] PORT_F = 4'd5;
    localparam logic [3:0] PORT_G = 4'd6;
    localparam logic [3:0] PORT_H = 4'd7;
    localparam logic [3:0] PORT_I = 4'd8;

    // sensitivity codes
    localparam logic [1:0] SENSE_FALL_LOW = 2'd0;
    localparam logic [1:0] SENSE_RISE     = 2'd1;
    localparam logic [1:0] SENSE_FALL     = 2'd2;

    typedef struct packed {
        logic       older_family;
        logic [3:0] port_index;
        logic [7:0] sense_ctrl_one;
        logic [7:0] sense_ctrl_two;
        logic [7:0] sense_ctrl_three;
        logic [7:0] sense_ctrl_four;
        logic [7:0] port_mode_sel_one;
        logic [7:0] port_mode_sel_two;
    } cfg_t;

    typedef struct packed {
        logic [7:0] output_latch;
        logic [7:0] pin_levels;
        logic [7:0] direction;
        logic [7:0] interrupt_enable;
        logic [7:0] status_one;
        logic [7:0] status_two;
    } port_state_t;

    function automatic logic nib_port_mode(input cfg_t c, input logic high);
        logic r;
        r = 1'b0;
        if (c.older_family) begin
            if (c.port_index <= PORT_F) begin
                r = 1'b1;
            end else if (c.port_index == PORT_G) begin
                r = high ? c.port_mode_sel_two[2] : c.port_mode_sel_two[1];
            end else if (c.port_index == PORT_H) begin
                r = high ? c.port_mode_sel_two[4] : c.port_mode_sel_two[3];
            end
        end else begin
            case (c.port_index)
                PORT_B:  r = high ? c.port_mode_sel_one[1] : c.port_mode_sel_one[0];
                PORT_D:  r = high ? c.port_mode_sel_one[3] : c.port_mode_sel_one[2];
                PORT_E:  r = high ? c.port_mode_sel_one[5] : c.port_mode_sel_one[4];
                PORT_F:  r = high ? c.port_mode_sel_two[0] : c.port_mode_sel_one[6];
                PORT_G:  r = high ? c.port_mode_sel_two[2] : c.port_mode_sel_two[1];
                PORT_H:  r = high ? c.port_mode_sel_two[4] : c.port_mode_sel_two[3];
                default: r = 1'b0;
            endcase
        end
        return r;
    endfunction

    function automatic logic port_routed(input cfg_t c);
        logic r;
        r = 1'b0;
        if (c.older_family) begin
            if (c.port_index <= PORT_E) begin
                r = 1'b1;
            end else if (c.port_index == PORT_G) begin
                r = c.port_mode_sel_two[5];
            end else if (c.port_index == PORT_H) begin
                r = c.port_mode_sel_two[6];
            end
        end else begin
            case (c.port_index)
                PORT_B:  r = ~c.port_mode_sel_two[5];
                PORT_D:  r = ~c.port_mode_sel_two[6];
                PORT_E:  r = ~c.port_mode_sel_one[7];
                PORT_F:  r = c.port_mode_sel_one[7];
                PORT_G:  r = c.port_mode_sel_two[5];
                PORT_H:  r = c.port_mode_sel_two[6];
                default: r = 1'b0;
            endcase
        end
        return r;
    endfunction

    function automatic logic [1:0] port_sense(input cfg_t c);
        logic [1:0] r;
        r = SENSE_FALL_LOW;
        if (c.older_family) begin
            case (c.port_index)
                PORT_A:  r = c.sense_ctrl_one[1:0];
                PORT_B:  r = c.sense_ctrl_one[3:2];
                PORT_C:  r = c.sense_ctrl_one[5:4];
                PORT_D:  r = c.sense_ctrl_one[7:6];
                PORT_E:  r = c.sense_ctrl_two[1:0];
                default: r = SENSE_FALL_LOW;
            endcase
        end else begin
            case (c.port_index)
                PORT_B:  r = c.sense_ctrl_three[1:0];
                PORT_D:  r = c.sense_ctrl_three[3:2];
                PORT_E:  r = c.sense_ctrl_three[5:4];
                PORT_F:  r = c.sense_ctrl_three[7:6];
                PORT_G:  r = c.sense_ctrl_four[1:0];
                PORT_H:  r = c.sense_ctrl_four[3:2];
                default: r = SENSE_FALL_LOW;
            endcase
        end
        return r;
    endfunction

endpackage

// ===== rtl/gpei_eval.sv =====
module gpei_eval
    import gpei_pkg::*;
(
    input  cfg_t        cfg,
    input  port_state_t st,
    input  logic [2:0]  func,
    input  logic [7:0]  value,
    output port_state_t st_next
);

    logic [7:0] lev, prev, dir, en, ie, base1, base2;
    logic [7:0] keep1, new1, new2;
    logic       check;
    logic       routed;
    logic [1:0] psense;

    assign check  = (func == FUNC_PINS) || (func == FUNC_DIR) || (func == FUNC_IE)
                 || (func == FUNC_STAT1) || (func == FUNC_STAT2);
    assign lev    = (func == FUNC_PINS) ? value : st.pin_levels;
    assign prev   = st.pin_levels;
    assign dir    = (func == FUNC_DIR) ? value : st.direction;
    assign en     = (func == FUNC_IE) ? value : st.interrupt_enable;
    assign ie     = ~dir & en;
    assign routed = port_routed(cfg);
    assign psense = port_sense(cfg);

    always_comb begin
        base1 = st.status_one;
        base2 = st.status_two;
        if (func == FUNC_STAT1) begin
            base1 = cfg.older_family ? value : (st.status_one & ~value);
        end
        if (func == FUNC_STAT2) begin
            base2 = cfg.older_family ? value : (st.status_two & ~value);
        end
    end

    always_comb begin
        logic [7:0] m;
        logic [7:0] crn;
        logic       fire;
        logic [1:0] s;
        logic [2:0] pin;
        keep1 = 8'hff;
        new1  = 8'h00;
        new2  = 8'h00;
        for (int h = 0; h < 2; h++) begin
            m   = (h == 1) ? 8'hf0 : 8'h0f;
            crn = (h == 1) ? cfg.sense_ctrl_two : cfg.sense_ctrl_one;
            if (nib_port_mode(cfg, h == 1)) begin
                if (routed) begin
                    case (psense)
                        SENSE_FALL_LOW: begin
                            if (cfg.older_family && cfg.port_index <= PORT_H) begin
                                keep1[cfg.port_index[2:0]] = 1'b0;
                            end
                            fire = (lev & ie & m) != (ie & m);
                        end
                        SENSE_RISE: fire = (ie & ~prev & lev & m) != 8'h00;
                        SENSE_FALL: fire = (ie & prev & ~lev & m) != 8'h00;
                        default:    fire = (ie & (prev ^ lev) & m) != 8'h00;
                    endcase
                    if (fire) begin
                        if (cfg.older_family) begin
                            if (cfg.port_index <= PORT_H) begin
                                new1[cfg.port_index[2:0]] = 1'b1;
                            end
                        end else if (cfg.port_index == PORT_B) begin
                            new2[0] = 1'b1;
                        end else if (cfg.port_index > PORT_C && cfg.port_index <= PORT_I) begin
                            new2[3'(cfg.port_index - 4'd2)] = 1'b1;
                        end
                    end
                end
            end else begin
                for (int i = 0; i < 4; i++) begin
                    pin = 3'(h * 4 + i);
                    s   = crn[2*i +: 2];
                    case (s)
                        SENSE_FALL_LOW: begin
                            if (cfg.older_family) begin
                                keep1[pin] = 1'b0;
                            end
                            fire = ie[pin] & ~lev[pin];
                        end
                        SENSE_RISE: fire = ie[pin] & ~prev[pin] & lev[pin];
                        SENSE_FALL: fire = ie[pin] & prev[pin] & ~lev[pin];
                        default:    fire = ie[pin] & (prev[pin] ^ lev[pin]);
                    endcase
                    if (fire) begin
                        new1[pin] = 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        st_next = st;
        if (check) begin
            st_next.status_one = (base1 & keep1) | new1;
            st_next.status_two = base2 | new2;
            if (func == FUNC_PINS || func == FUNC_DIR) begin
                st_next.pin_levels = (lev & ~dir) | (st.output_latch & dir);
            end
            if (func == FUNC_DIR) begin
                st_next.direction = value;
            end
            if (func == FUNC_IE) begin
                st_next.interrupt_enable = value;
            end
        end else if (func == FUNC_LATCH) begin
            st_next.output_latch = value;
            st_next.pin_levels   = (st.pin_levels & ~st.direction) | (value & st.direction);
        end
    end

endmodule

// ===== rtl/gpio_port_external_interrupt.sv =====
// 8-bit GPIO port with external interrupt detection.
//
// s_ channel: one register write request per item (func selects the target:
// output latch, external pin levels, direction, interrupt enable, status one
// or status two). m_ channel: one result per request with the pin levels and
// both status registers as they stand after the write.
// cfg_ port: plain write port for the eight setup registers; write it only
// while no request is in flight.
//
// A request accepted on s_ is registered in the input register, evaluated
// combinationally and registered in the output register that drives m_.
// Throughput: one request per cycle while m_ is not stalled; the only work is
// the combinational evaluation between the input and output registers.
// When m_tready is low the result holds, the input register still takes one
// more request, and s_tready then drops until the result is taken.
// Reset clears all port registers, setup registers and both channel valids.
module gpio_port_external_interrupt
    import gpei_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [2:0] func, [10:3] value, zero fill

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] pin_value, [15:8] status_one_value,
                                   // [23:16] status_two_value

    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_wdata
);

    cfg_t        cfg_reg;
    port_state_t st_reg, st_next;

    logic        in_valid_reg;
    logic [2:0]  in_func_reg;
    logic [7:0]  in_value_reg;
    logic        m_tvalid_reg;
    logic [23:0] m_tdata_reg;
    logic        advance;

    assign advance  = ~m_tvalid_reg | m_tready;
    assign s_tready = ~in_valid_reg | advance;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_OLDER:       cfg_reg.older_family      <= cfg_wdata[0];
                CFG_PORT_INDEX:  cfg_reg.port_index        <= cfg_wdata[3:0];
                CFG_SENSE_ONE:   cfg_reg.sense_ctrl_one    <= cfg_wdata;
                CFG_SENSE_TWO:   cfg_reg.sense_ctrl_two    <= cfg_wdata;
                CFG_SENSE_THREE: cfg_reg.sense_ctrl_three  <= cfg_wdata;
                CFG_SENSE_FOUR:  cfg_reg.sense_ctrl_four   <= cfg_wdata;
                CFG_MODE_ONE:    cfg_reg.port_mode_sel_one <= cfg_wdata;
                CFG_MODE_TWO:    cfg_reg.port_mode_sel_two <= cfg_wdata;
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_func_reg  <= s_tdata[2:0];
            in_value_reg <= s_tdata[10:3];
        end
    end

    gpei_eval u_eval (
        .cfg     (cfg_reg),
        .st      (st_reg),
        .func    (in_func_reg),
        .value   (in_value_reg),
        .st_next (st_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            m_tvalid_reg <= in_valid_reg;
            if (in_valid_reg) begin
                st_reg <= st_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            m_tdata_reg <= {st_next.status_two, st_next.status_one, st_next.pin_levels};
        end
    end

    a_hold_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && m_tvalid_reg && !m_tready) |=> in_valid_reg)
        else $error("pending request dropped while result stalled");

    a_latch_keeps_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_valid_reg && in_func_reg == FUNC_LATCH)
        |=> (st_reg.status_one == $past(st_reg.status_one)
             && st_reg.status_two == $past(st_reg.status_two)))
        else $error("output latch write changed status");

    a_output_mirror: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_valid_reg
         && (in_func_reg == FUNC_LATCH || in_func_reg == FUNC_PINS))
        |=> ((st_reg.pin_levels & st_reg.direction)
             == (st_reg.output_latch & st_reg.direction)))
        else $error("output pins not mirrored from latch");

endmodule
